### rtl/core/shift_insert_delete_list_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shift/insert/delete list.
// Both macros expect aclk, and SIDL_ASSERT also aresetn, to be visible in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef SHIFT_INSERT_DELETE_LIST_ASSERT_SVH
`define SHIFT_INSERT_DELETE_LIST_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define SIDL_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sidl assertion failed");
// Checked at every edge, reset included.
`define SIDL_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("sidl assertion failed");
`else
`define SIDL_ASSERT(label, prop)
`define SIDL_ASSERT_ALWAYS(label, prop)
`endif

`endif

### rtl/core/sidl_pkg.sv
// ----------------------------------------------------------------------------
// sidl_pkg
// Types and constants shared by the shift/insert/delete list modules.
// ----------------------------------------------------------------------------
package sidl_pkg;

    localparam int ACTION_W    = 2;
    localparam int POS_W       = 5;
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_SHIFT_UP   = 2'd2,
        CELL_SHIFT_DOWN = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic    commit;
        logic    read_hit;
        status_t status;
    } decision_t;

endpackage

### rtl/core/sidl_cell.sv
// ----------------------------------------------------------------------------
// sidl_cell
// One list entry. Loads a new value, takes its lower or upper neighbor, or holds.
// ----------------------------------------------------------------------------
module sidl_cell (
    input  logic                          aclk,
    input  sidl_pkg::cell_op_t            op,
    input  logic [sidl_pkg::DATA_W-1:0]   load_data,
    input  logic [sidl_pkg::DATA_W-1:0]   lower_data,
    input  logic [sidl_pkg::DATA_W-1:0]   upper_data,
    output logic [sidl_pkg::DATA_W-1:0]   data
);

    logic [sidl_pkg::DATA_W-1:0] data_reg;
    logic [sidl_pkg::DATA_W-1:0] data_next;

    always_comb begin
        case (op)
            sidl_pkg::CELL_LOAD:       data_next = load_data;
            sidl_pkg::CELL_SHIFT_UP:   data_next = lower_data;
            sidl_pkg::CELL_SHIFT_DOWN: data_next = upper_data;
            default:                   data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/core/sidl_ctrl.sv
// ----------------------------------------------------------------------------
// sidl_ctrl
// Decodes one request against the current count: status, new count and the
// operation of every cell in the chain.
// ----------------------------------------------------------------------------
module sidl_ctrl #(
    parameter int DEPTH = 16,
    parameter int CW    = 5
) (
    input  logic                          fire,
    input  sidl_pkg::action_t             action,
    input  logic [sidl_pkg::POS_W-1:0]    position,
    input  logic [CW-1:0]                 count,
    output sidl_pkg::decision_t           decision,
    output logic [CW-1:0]                 count_next,
    output sidl_pkg::cell_op_t            cell_op [DEPTH]
);

    localparam int LW = (CW > sidl_pkg::POS_W) ? CW : sidl_pkg::POS_W;

    logic [LW-1:0] pos_ext;
    logic [LW-1:0] count_ext;
    logic          full;
    logic          pos_above;
    logic          pos_at_or_above;

    assign pos_ext         = LW'(position);
    assign count_ext       = LW'(count);
    assign full            = count_ext >= LW'(DEPTH);
    assign pos_above       = pos_ext > count_ext;
    assign pos_at_or_above = pos_ext >= count_ext;

    always_comb begin
        decision.commit   = 1'b0;
        decision.read_hit = 1'b0;
        decision.status   = sidl_pkg::ST_OK;
        count_next        = count;
        case (action)
            sidl_pkg::ACT_APPEND: begin
                if (full) begin
                    decision.status = sidl_pkg::ST_FULL;
                end else begin
                    decision.commit = 1'b1;
                    count_next      = count + CW'(1);
                end
            end
            sidl_pkg::ACT_INSERT: begin
                if (full) begin
                    decision.status = sidl_pkg::ST_FULL;
                end else if (pos_above) begin
                    decision.status = sidl_pkg::ST_RANGE;
                end else begin
                    decision.commit = 1'b1;
                    count_next      = count + CW'(1);
                end
            end
            sidl_pkg::ACT_DELETE: begin
                if (pos_at_or_above) begin
                    decision.status = sidl_pkg::ST_RANGE;
                end else begin
                    decision.commit = 1'b1;
                    count_next      = count - CW'(1);
                end
            end
            default: begin
                if (pos_at_or_above) begin
                    decision.status = sidl_pkg::ST_RANGE;
                end else begin
                    decision.read_hit = 1'b1;
                end
            end
        endcase
    end

    // Each cell compares its own index with the position and the count.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_op[i] = sidl_pkg::CELL_HOLD;
            if (fire && decision.commit) begin
                case (action)
                    sidl_pkg::ACT_APPEND: begin
                        if (LW'(i) == count_ext) cell_op[i] = sidl_pkg::CELL_LOAD;
                    end
                    sidl_pkg::ACT_INSERT: begin
                        if (LW'(i) == pos_ext) begin
                            cell_op[i] = sidl_pkg::CELL_LOAD;
                        end else if (LW'(i) > pos_ext && LW'(i) <= count_ext) begin
                            cell_op[i] = sidl_pkg::CELL_SHIFT_UP;
                        end
                    end
                    sidl_pkg::ACT_DELETE: begin
                        if (LW'(i) >= pos_ext && LW'(i + 1) < count_ext) begin
                            cell_op[i] = sidl_pkg::CELL_SHIFT_DOWN;
                        end
                    end
                    default: cell_op[i] = sidl_pkg::CELL_HOLD;
                endcase
            end
        end
    end

endmodule

### rtl/core/shift_insert_delete_list.sv
// ----------------------------------------------------------------------------
// shift_insert_delete_list
// The result of an accepted input transfer is registered and appears on m_tdata in the next cycle.
// Throughput: one item per cycle while the output is not stalled; the whole chain of cells shifts together.
// The output register frees as its result is taken, so s_tready stays high
// while m_tready is high.
// Reset clears the count and the output valid; entries are undefined until written.
// ----------------------------------------------------------------------------
`include "shift_insert_delete_list_assert.svh"

module shift_insert_delete_list #(
    parameter int DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] action, [6:2] position, [38:7] value, [39] zero
    input  logic [sidl_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] read_value, [36:32] element_count, [38:37] status, [39] zero
    output logic [sidl_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    sidl_pkg::action_t                 action;
    logic [sidl_pkg::POS_W-1:0]        position;
    logic [sidl_pkg::DATA_W-1:0]       value;
    logic                              fire;

    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    sidl_pkg::decision_t               decision;
    sidl_pkg::cell_op_t                cell_op [DEPTH];
    logic [sidl_pkg::DATA_W-1:0]       entry [DEPTH];

    logic [IW-1:0]                     rd_idx;
    logic [sidl_pkg::DATA_W-1:0]       rd_value;

    logic                              m_tvalid_reg;
    logic [sidl_pkg::M_TDATA_W-1:0]    m_tdata_reg;

    assign action   = sidl_pkg::action_t'(s_tdata[1:0]);
    assign position = s_tdata[6:2];
    assign value    = s_tdata[38:7];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    sidl_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .fire       (fire),
        .action     (action),
        .position   (position),
        .count      (count_reg),
        .decision   (decision),
        .count_next (count_next),
        .cell_op    (cell_op)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [sidl_pkg::DATA_W-1:0] lower;
        logic [sidl_pkg::DATA_W-1:0] upper;

        if (g == 0) begin : g_first
            assign lower = '0;
        end else begin : g_mid_lo
            assign lower = entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign upper = '0;
        end else begin : g_mid_hi
            assign upper = entry[g+1];
        end

        sidl_cell u_cell (
            .aclk       (aclk),
            .op         (cell_op[g]),
            .load_data  (value),
            .lower_data (lower),
            .upper_data (upper),
            .data       (entry[g])
        );
    end

    // A read hit implies position < count <= DEPTH, so the index is in range.
    assign rd_idx   = IW'(position);
    assign rd_value = decision.read_hit ? entry[rd_idx] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (fire) begin
                count_reg <= count_next;
            end
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= {1'b0, decision.status,
                            sidl_pkg::COUNT_OUT_W'(count_next), rd_value};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SIDL_ASSERT(a_count_in_range, count_reg <= CW'(DEPTH))
    `SIDL_ASSERT(a_count_idle_stable, !fire |=> $stable(count_reg))
    `SIDL_ASSERT(a_reject_keeps_count, fire && decision.status != sidl_pkg::ST_OK |=> $stable(count_reg))
    `SIDL_ASSERT(a_zero_unless_hit, fire && !decision.read_hit |=> m_tdata_reg[31:0] == '0)
    `SIDL_ASSERT_ALWAYS(a_reset_clears_valid, !aresetn |=> !m_tvalid_reg)

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for shift_insert_delete_list
// A directed run through the edge cases of the list (empty, full, positions at
// and past the end, extreme values) is followed by random append, insert,
// delete and read traffic that drifts between growing and shrinking the list.
// Every result is compared field by field with a behavioral copy of the list.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIST_DEPTH  = 16;
    localparam int RANDOM_CMDS = 600;

    typedef struct {
        logic signed [sidl_pkg::DATA_W-1:0] read_value;
        logic [sidl_pkg::COUNT_OUT_W-1:0]   element_count;
        sidl_pkg::status_t                  status;
    } list_result_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [sidl_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [sidl_pkg::M_TDATA_W-1:0]  m_tdata;

    // Commands waiting to be driven, and results the list should return.
    logic [sidl_pkg::S_TDATA_W-1:0]  pending_cmds[$];
    list_result_t                    expected_results[$];

    // Behavioral copy of the list.
    logic signed [sidl_pkg::DATA_W-1:0] list_store[LIST_DEPTH];
    int unsigned                        list_len = 0;
    int unsigned                        peak_len = 0;

    int  cmds_total   = 0;
    int  cmds_taken   = 0;
    int  results_seen = 0;
    int  fail_count   = 0;
    int  n_ok         = 0;
    int  n_full       = 0;
    int  n_range      = 0;
    logic steady;

    shift_insert_delete_list #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Neither side idles while this window of results is passing.
    assign steady = (results_seen >= 250) && (results_seen < 380);

    function automatic list_result_t apply_list_op(logic [sidl_pkg::S_TDATA_W-1:0] word);
        sidl_pkg::action_t                  act;
        int unsigned                        pos;
        logic signed [sidl_pkg::DATA_W-1:0] val;
        list_result_t                       res;
        act = sidl_pkg::action_t'(word[1:0]);
        pos = word[6:2];
        val = word[38:7];
        res.read_value = '0;
        res.status     = sidl_pkg::ST_OK;
        case (act)
            sidl_pkg::ACT_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = sidl_pkg::ST_FULL;
                end else begin
                    list_store[list_len] = val;
                    list_len++;
                end
            end
            sidl_pkg::ACT_INSERT: begin
                // A full list is refused before the position is looked at.
                if (list_len >= LIST_DEPTH) begin
                    res.status = sidl_pkg::ST_FULL;
                end else if (pos > list_len) begin
                    res.status = sidl_pkg::ST_RANGE;
                end else begin
                    for (int i = list_len; i > pos; i--)
                        list_store[i] = list_store[i-1];
                    list_store[pos] = val;
                    list_len++;
                end
            end
            sidl_pkg::ACT_DELETE: begin
                if (pos >= list_len) begin
                    res.status = sidl_pkg::ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < list_len; i++)
                        list_store[i] = list_store[i+1];
                    list_len--;
                end
            end
            default: begin
                if (pos >= list_len)
                    res.status = sidl_pkg::ST_RANGE;
                else
                    res.read_value = list_store[pos];
            end
        endcase
        if (list_len > peak_len)
            peak_len = list_len;
        res.element_count = list_len[sidl_pkg::COUNT_OUT_W-1:0];
        return res;
    endfunction

    task automatic queue_cmd(sidl_pkg::action_t act, int unsigned pos,
                             logic [sidl_pkg::DATA_W-1:0] val);
        pending_cmds.push_back({1'b0, val, pos[sidl_pkg::POS_W-1:0], act});
        cmds_total++;
    endtask

    // Input side: a new transfer is offered only once the previous one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_cmds.size() > 0 && (steady || $urandom_range(99) >= 31)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_cmds.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(99) >= 31);
    end

    // Result side: predict on each accepted command, check each result transfer.
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_list_op(s_tdata));
                cmds_taken++;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.read_value) begin
                        $display("%0t: read_value expected %h, got %h",
                                 $time, want.read_value, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[36:32] !== want.element_count) begin
                        $display("%0t: element_count expected %0d, got %0d",
                                 $time, want.element_count, m_tdata[36:32]);
                        fail_count++;
                    end
                    if (m_tdata[38:37] !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_tdata[38:37]);
                        fail_count++;
                    end
                    case (want.status)
                        sidl_pkg::ST_OK:   n_ok++;
                        sidl_pkg::ST_FULL: n_full++;
                        default:           n_range++;
                    endcase
                end
            end
        end
    end

    initial begin
        int unsigned                 shadow_len;
        int                          mode;
        int                          mode_left;
        int unsigned                 pick;
        int unsigned                 pos;
        sidl_pkg::action_t           act;
        logic [sidl_pkg::DATA_W-1:0] val;

        // Empty list: every positional request is out of range.
        queue_cmd(sidl_pkg::ACT_READ,   0, 32'h1234_5678);
        queue_cmd(sidl_pkg::ACT_DELETE, 0, '0);
        queue_cmd(sidl_pkg::ACT_INSERT, 1, 32'hDEAD_BEEF);
        // Insert at the head of an empty list, then extremes and insert at the end.
        queue_cmd(sidl_pkg::ACT_INSERT, 0, 32'h7FFF_FFFF);
        queue_cmd(sidl_pkg::ACT_APPEND, 31, 32'h8000_0000);
        queue_cmd(sidl_pkg::ACT_INSERT, 2, 32'h0000_0000);
        queue_cmd(sidl_pkg::ACT_INSERT, 1, 32'hFFFF_FFFF);
        queue_cmd(sidl_pkg::ACT_READ,   1, '0);
        queue_cmd(sidl_pkg::ACT_READ,   4, '0);
        queue_cmd(sidl_pkg::ACT_DELETE, 1, 32'hFFFF_FFFF);
        queue_cmd(sidl_pkg::ACT_DELETE, 2, '0);
        // Fill to capacity, then push against the full list.
        for (int i = 0; i < LIST_DEPTH - 2; i++)
            queue_cmd(sidl_pkg::ACT_APPEND, 0, {i[7:0], ~i[7:0], i[7:0], ~i[7:0]});
        queue_cmd(sidl_pkg::ACT_APPEND, 0, 32'h5555_5555);
        queue_cmd(sidl_pkg::ACT_INSERT, 0, 32'hAAAA_AAAA);
        queue_cmd(sidl_pkg::ACT_INSERT, 16, 32'hAAAA_AAAA);
        queue_cmd(sidl_pkg::ACT_READ,   15, '0);
        queue_cmd(sidl_pkg::ACT_READ,   16, '0);
        queue_cmd(sidl_pkg::ACT_DELETE, 0, '0);
        queue_cmd(sidl_pkg::ACT_DELETE, 16, '0);
        shadow_len = LIST_DEPTH - 1;

        // Random traffic alternating between growing, shrinking and mixed phases.
        mode      = 0;
        mode_left = 0;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (mode_left == 0) begin
                mode      = $urandom_range(2);
                mode_left = $urandom_range(60, 20);
            end
            mode_left--;
            pick = $urandom_range(99);
            case (mode)
                0:       act = (pick < 35) ? sidl_pkg::ACT_APPEND :
                               (pick < 70) ? sidl_pkg::ACT_INSERT :
                               (pick < 80) ? sidl_pkg::ACT_DELETE : sidl_pkg::ACT_READ;
                1:       act = (pick < 10) ? sidl_pkg::ACT_APPEND :
                               (pick < 20) ? sidl_pkg::ACT_INSERT :
                               (pick < 70) ? sidl_pkg::ACT_DELETE : sidl_pkg::ACT_READ;
                default: act = (pick < 25) ? sidl_pkg::ACT_APPEND :
                               (pick < 50) ? sidl_pkg::ACT_INSERT :
                               (pick < 75) ? sidl_pkg::ACT_DELETE : sidl_pkg::ACT_READ;
            endcase
            if ($urandom_range(99) < 15)
                pos = $urandom_range(16);
            else if (act == sidl_pkg::ACT_INSERT || act == sidl_pkg::ACT_APPEND)
                pos = $urandom_range(shadow_len);
            else
                pos = (shadow_len > 0) ? $urandom_range(shadow_len - 1) : 0;
            case ($urandom_range(39))
                0:       val = 32'h7FFF_FFFF;
                1:       val = 32'h8000_0000;
                2:       val = 32'hFFFF_FFFF;
                3:       val = 32'h0000_0000;
                default: val = $urandom;
            endcase
            queue_cmd(act, pos, val);
            // Track only the length so that positions stay mostly meaningful.
            case (act)
                sidl_pkg::ACT_APPEND: if (shadow_len < LIST_DEPTH) shadow_len++;
                sidl_pkg::ACT_INSERT:
                    if (shadow_len < LIST_DEPTH && pos <= shadow_len) shadow_len++;
                sidl_pkg::ACT_DELETE: if (pos < shadow_len) shadow_len--;
                default: ;
            endcase
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmds_taken < cmds_total || expected_results.size() > 0)
            @(posedge aclk);
        repeat (5) @(posedge aclk);

        $display("Ran %0d list commands: %0d completed, %0d refused as full, %0d out of range.",
                 cmds_taken, n_ok, n_full, n_range);
        $display("The list reached a peak length of %0d of %0d entries.", peak_len, LIST_DEPTH);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Run timed out with %0d of %0d commands taken.", cmds_taken, cmds_total);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
